[design/b64sd_pkg.sv]
`default_nettype none

package b64sd_pkg;

    // Character and byte codes
    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
    localparam logic [7:0] CR_BYTE  = 8'h0D;  // carriage return
    localparam logic [6:0] NOT_B64  = 7'd127; // marks a character outside the alphabet

    // Reset value of the drop_carriage_return register
    localparam logic DROP_CR_RESET = 1'b1;

    // Sextet value of one base64 alphabet character, NOT_B64 for anything else
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'd0;
        case (ch) inside
            [8'h41:8'h5A]: t = ch - 8'h41;          // 'A'..'Z' -> 0..25
            [8'h61:8'h7A]: t = ch - 8'h61 + 8'd26;  // 'a'..'z' -> 26..51
            [8'h30:8'h39]: t = ch - 8'h30 + 8'd52;  // '0'..'9' -> 52..61
            8'h2B:         t = 8'd62;               // '+'
            8'h2F:         t = 8'd63;               // '/'
            default:       t = {1'b0, NOT_B64};
        endcase
        return t[6:0];
    endfunction

endpackage

`default_nettype wire

[design/base64_stream_decoder_top.sv]
`default_nettype none

// Base64 stream decoder. Takes one text character per s_axis transaction
// (tlast marks the final character of a string) and returns decoded bytes on
// m_axis, where tuser is 1 for a real data byte and 0 for the empty marker
// that closes a string which produced no byte on its last character. Bytes
// outside the base64 alphabet are skipped; a '=' pad ends the data and later
// characters are ignored until tlast, which also discards a partial quad.
// Decoded carriage returns are dropped while cfg bit drop_carriage_return is
// set (reset value 1); write it only while the block is idle. Rate: one
// character per clock while no decoded byte is waiting. The character that
// completes a quad loads up to three bytes into the result buffer, which
// drains one byte per clock while m_axis_tready is high; s_axis_tready is
// high only while the buffer is empty or its one remaining byte leaves in
// the same cycle. So a quad that keeps two or three bytes stalls the input
// until all of its bytes but the last have left, and every cycle that
// m_axis_tready is low while bytes wait adds a stall.
module base64_stream_decoder_top
    import b64sd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wdata,     // drop_carriage_return
    // input characters
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] in_char
    input  wire logic       s_axis_tlast,  // in_last
    // decoded bytes
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
    output logic            m_axis_tuser,  // [0] out_valid
    output logic            m_axis_tlast   // out_last
);

    // Decoder state
    logic        drop_cr_reg;
    logic [1:0]  quad_pos_reg,  quad_pos_next;
    logic [17:0] sextets_reg,   sextets_next;
    logic [2:0]  pads_reg,      pads_next;
    logic        done_reg,      done_next;

    // Result buffer: up to three bytes, entry 0 is presented
    logic [7:0]  byte_reg [3];
    logic [7:0]  byte_next [3];
    logic [1:0]  cnt_reg,    cnt_next;
    logic        filler_reg, filler_next;
    logic        last_reg,   last_next;

    logic        s_accept, m_pop;
    logic [7:0]  ch;
    logic        is_pad, is_sym;
    logic [6:0]  sx_raw;
    logic [5:0]  sx, s0, s1, s2;
    logic [7:0]  b0, b1, b2;
    logic        e0, e1, e2;
    logic        k0, k1, k2;
    logic [1:0]  n_out;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_pop    = m_axis_tvalid && m_axis_tready;

    // Take a character when the buffer is empty or its final byte leaves now
    assign s_axis_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = byte_reg[0];
    assign m_axis_tuser  = !filler_reg;
    assign m_axis_tlast  = last_reg && (cnt_reg == 2'd1);

    // Character classification
    assign ch     = s_axis_tdata;
    assign is_pad = (ch == PAD_CHAR);
    assign sx_raw = sextet_of(ch);
    assign is_sym = is_pad || (sx_raw != NOT_B64);
    assign sx     = is_pad ? 6'd0 : sx_raw[5:0];

    // Quad bytes, formed from the held sextets and the incoming fourth one
    assign s0 = sextets_reg[5:0];
    assign s1 = sextets_reg[11:6];
    assign s2 = sextets_reg[17:12];
    assign b0 = {s0, s1[5:4]};
    assign b1 = {s1[3:0], s2[5:2]};
    assign b2 = {s2[1:0], sx};

    // Keep a byte unless it is a carriage return being dropped
    assign k0 = e0 && !(drop_cr_reg && b0 == CR_BYTE);
    assign k1 = e1 && !(drop_cr_reg && b1 == CR_BYTE);
    assign k2 = e2 && !(drop_cr_reg && b2 == CR_BYTE);
    assign n_out = 2'({1'b0, k0} + {1'b0, k1} + {1'b0, k2});

    // Quad collection and end-of-data tracking
    always_comb begin
        quad_pos_next = quad_pos_reg;
        sextets_next  = sextets_reg;
        pads_next     = pads_reg;
        done_next     = done_reg;
        e0 = 1'b0;
        e1 = 1'b0;
        e2 = 1'b0;
        if (s_accept) begin
            if (!done_reg && is_sym) begin
                if (quad_pos_reg != 2'd3) begin
                    case (quad_pos_reg)
                        2'd0:    sextets_next[5:0]   = sx;
                        2'd1:    sextets_next[11:6]  = sx;
                        2'd2:    sextets_next[17:12] = sx;
                        default: sextets_next        = sextets_reg;
                    endcase
                    pads_next[quad_pos_reg] = is_pad;
                    quad_pos_next = quad_pos_reg + 2'd1;
                end else begin
                    if (pads_reg[0] || pads_reg[1]) begin
                        done_next = 1'b1;
                    end else begin
                        e0 = 1'b1;
                        if (pads_reg[2]) begin
                            done_next = 1'b1;
                        end else begin
                            e1 = 1'b1;
                            if (is_pad) begin
                                done_next = 1'b1;
                            end else begin
                                e2 = 1'b1;
                            end
                        end
                    end
                    quad_pos_next = 2'd0;
                    sextets_next  = '0;
                    pads_next     = '0;
                end
            end
            // End of string discards everything held
            if (s_axis_tlast) begin
                quad_pos_next = 2'd0;
                sextets_next  = '0;
                pads_next     = '0;
                done_next     = 1'b0;
            end
        end
    end

    // Result buffer load (kept bytes packed to the front) and drain
    always_comb begin
        byte_next[0] = byte_reg[0];
        byte_next[1] = byte_reg[1];
        byte_next[2] = byte_reg[2];
        cnt_next     = cnt_reg;
        filler_next  = filler_reg;
        last_next    = last_reg;
        if (s_accept) begin
            if (s_axis_tlast && n_out == 2'd0) begin
                byte_next[0] = 8'd0;
                cnt_next     = 2'd1;
                filler_next  = 1'b1;
                last_next    = 1'b1;
            end else begin
                byte_next[0] = k0 ? b0 : (k1 ? b1 : b2);
                byte_next[1] = (k0 && k1) ? b1 : b2;
                byte_next[2] = b2;
                cnt_next     = n_out;
                filler_next  = 1'b0;
                last_next    = s_axis_tlast;
            end
        end else if (m_pop) begin
            byte_next[0] = byte_reg[1];
            byte_next[1] = byte_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_cr_reg  <= DROP_CR_RESET;
            quad_pos_reg <= 2'd0;
            sextets_reg  <= '0;
            pads_reg     <= '0;
            done_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            filler_reg   <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                drop_cr_reg <= cfg_wdata;
            end
            quad_pos_reg <= quad_pos_next;
            sextets_reg  <= sextets_next;
            pads_reg     <= pads_next;
            done_reg     <= done_next;
            cnt_reg      <= cnt_next;
            filler_reg   <= filler_next;
            last_reg     <= last_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        byte_reg[0] <= byte_next[0];
        byte_reg[1] <= byte_next[1];
        byte_reg[2] <= byte_next[2];
    end

`ifndef SYNTHESIS
    // A new group never lands on bytes still waiting to leave
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cnt_reg != 2'd0) |-> (cnt_reg == 2'd1 && m_axis_tready))
        else $error("result buffer overwritten");

    // The empty marker is always a single, final transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && filler_reg) |-> (cnt_reg == 2'd1 && last_reg))
        else $error("empty marker not alone or not last");

    // End of string leaves a clean decoder
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tlast) |=>
            (quad_pos_reg == 2'd0 && pads_reg == 3'd0 && !done_reg))
        else $error("state kept across end of string");

    // Once data has ended no quad is being collected
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (quad_pos_reg == 2'd0 && sextets_reg == 18'd0))
        else $error("quad collected after end of data");
`endif

endmodule

`default_nettype wire
